### rtl/core/dirs_pkg.sv
// Package for the drain-and-idle reset sequencer.
// Holds phase, kind and status codes, field widths and constants.
// No dependencies; used by the channel interfaces and the core.
`default_nettype none

package dirs_pkg;

   localparam int unsigned CNT_W      = 16;
   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned ACT_W      = 16;
   localparam int unsigned CODE_W     = 2;
   localparam int unsigned STREAK_W   = 2;

   localparam logic [CNT_W-1:0]    MAX_POLLS_RESET   = 16'd1000;
   localparam logic [ACT_W-1:0]    ACTIVITY_MASK     = 16'hffff;
   localparam logic [STREAK_W-1:0] IDLE_POLLS_NEEDED = 2'd2;

   typedef enum logic [2:0] {
      PH_NONE     = 3'd0,
      PH_DRAIN    = 3'd1,
      PH_PREDELAY = 3'd2,
      PH_IDLE     = 3'd3,
      PH_PKT_ACK  = 3'd4,
      PH_BUF_ACK  = 3'd5
   } phase_type;

   typedef enum logic [CODE_W-1:0] {
      K_START = 2'd0,
      K_POLL  = 2'd1,
      K_ACK   = 2'd2
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      ST_OK      = 2'd0,
      ST_TIMEOUT = 2'd1,
      ST_FAIL    = 2'd2
   } status_type;

   // code 3 counts as other failure
   function automatic status_type norm_status(input logic [CODE_W-1:0] code);
      status_type res;
      case (code)
         ST_OK:      res = ST_OK;
         ST_TIMEOUT: res = ST_TIMEOUT;
         default:    res = ST_FAIL;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/core/dirs_req_if.sv
// Request channel of the reset sequencer: valid/ready plus one item.
// Depends on dirs_pkg for field widths.
`default_nettype none

interface dirs_req_if
   import dirs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   kind;
   logic [WORD_W-1:0]   target_value;
   logic [WORD_W-1:0]   observed_value;
   logic [ACT_W-1:0]    activity_word;
   logic [CODE_W-1:0]   reported_status;

   modport source (output valid, kind, target_value, observed_value,
                   activity_word, reported_status, input ready);
   modport sink   (input valid, kind, target_value, observed_value,
                   activity_word, reported_status, output ready);
endinterface

`default_nettype wire

### rtl/core/dirs_rsp_if.sv
// Response channel of the reset sequencer: valid/ready plus one result.
// Depends on dirs_pkg for field widths.
`default_nettype none

interface dirs_rsp_if
   import dirs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                sequence_done;
   logic [CODE_W-1:0]   final_status;
   logic                request_packet_reset;
   logic                request_buffer_reset;
   logic [CNT_W-1:0]    drain_polls_used;
   logic [CNT_W-1:0]    idle_polls_used;
   logic [TOTAL_W-1:0]  completed_total;
   logic [TOTAL_W-1:0]  timeout_total;
   logic [TOTAL_W-1:0]  failure_total;

   modport source (output valid, sequence_done, final_status,
                   request_packet_reset, request_buffer_reset,
                   drain_polls_used, idle_polls_used, completed_total,
                   timeout_total, failure_total, input ready);
   modport sink   (input valid, sequence_done, final_status,
                   request_packet_reset, request_buffer_reset,
                   drain_polls_used, idle_polls_used, completed_total,
                   timeout_total, failure_total, output ready);
endinterface

`default_nettype wire

### rtl/core/drain_and_idle_reset_sequencer.sv
// Top level of the drain-and-idle reset sequencer: phase control,
// poll counting and outcome counters. Uses dirs_pkg, dirs_req_if, dirs_rsp_if.
//
//   channel   dir   handshake        beat
//   req_ch    in    valid/ready      kind, target/observed, activity, status
//   rsp_ch    out   valid/ready      done, status, requests, counts, totals
//   csr_*     in    csr_wr_en        max polls per wait phase (16 bits)
//
// One beat per cycle unless the response stalls: each request beat is decided
// in the cycle it is taken and its response lands in the output register on that edge.
// A request is taken while the output register is empty or being drained.
// Synchronous active-high reset: phase none, all counts zero, limit 1000.
// Response stall holds all state; counts shown are the live state registers.
`default_nettype none

module drain_and_idle_reset_sequencer
   import dirs_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   dirs_req_if.sink         req_ch,
   dirs_rsp_if.source       rsp_ch,
   input  wire              csr_wr_en,
   input  wire [CNT_W-1:0]  csr_wr_data
);

   logic [CNT_W-1:0]    max_polls_ff;
   phase_type           phase_ff, phase_in;
   logic [CNT_W-1:0]    poll_ff, poll_in;
   logic [STREAK_W-1:0] streak_ff, streak_in;
   logic [CNT_W-1:0]    drain_ff, drain_in;
   logic [CNT_W-1:0]    idle_ff, idle_in;
   logic [TOTAL_W-1:0]  succ_ff, succ_in;
   logic [TOTAL_W-1:0]  tout_ff, tout_in;
   logic [TOTAL_W-1:0]  fail_ff, fail_in;

   logic                rsp_valid_ff;
   logic                done_ff, done_in;
   status_type          fstat_ff, fstat_in;
   logic                req_pkt_ff, req_pkt_in;
   logic                req_buf_ff, req_buf_in;

   logic                req_fire;
   logic [CNT_W-1:0]    poll_next;
   logic [STREAK_W-1:0] streak_upd;
   status_type          status;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign poll_next    = poll_ff + 1'b1;
   assign status       = norm_status(req_ch.reported_status);

   always_comb begin
      if ((req_ch.activity_word & ACTIVITY_MASK) == '0) begin
         streak_upd = (streak_ff < IDLE_POLLS_NEEDED) ? streak_ff + 1'b1 : streak_ff;
      end else begin
         streak_upd = '0;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      poll_in    = poll_ff;
      streak_in  = streak_ff;
      drain_in   = drain_ff;
      idle_in    = idle_ff;
      succ_in    = succ_ff;
      tout_in    = tout_ff;
      fail_in    = fail_ff;
      done_in    = 1'b0;
      fstat_in   = ST_OK;
      req_pkt_in = 1'b0;
      req_buf_in = 1'b0;

      case (phase_ff)
         PH_NONE: begin
            if (req_ch.kind == K_START) begin
               drain_in  = '0;
               idle_in   = '0;
               poll_in   = '0;
               streak_in = '0;
               phase_in  = PH_DRAIN;
               if (max_polls_ff == '0) begin
                  done_in  = 1'b1;
                  fstat_in = ST_TIMEOUT;
               end
            end
         end
         PH_DRAIN: begin
            if (req_ch.kind == K_POLL) begin
               if (req_ch.target_value == req_ch.observed_value) begin
                  drain_in = poll_next;
                  poll_in  = '0;
                  phase_in = PH_PREDELAY;
               end else if (status != ST_OK) begin
                  drain_in = poll_next;
                  done_in  = 1'b1;
                  fstat_in = status;
               end else begin
                  poll_in = poll_next;
                  if (poll_next >= max_polls_ff) begin
                     drain_in = max_polls_ff;
                     done_in  = 1'b1;
                     fstat_in = ST_TIMEOUT;
                  end
               end
            end
         end
         PH_PREDELAY: begin
            if (req_ch.kind == K_POLL) begin
               if (status != ST_OK) begin
                  done_in  = 1'b1;
                  fstat_in = status;
               end else begin
                  poll_in   = '0;
                  streak_in = '0;
                  phase_in  = PH_IDLE;
                  if (max_polls_ff == '0) begin
                     idle_in  = max_polls_ff;
                     done_in  = 1'b1;
                     fstat_in = ST_TIMEOUT;
                  end
               end
            end
         end
         PH_IDLE: begin
            if (req_ch.kind == K_POLL) begin
               streak_in = streak_upd;
               if (status != ST_OK) begin
                  idle_in  = poll_next;
                  done_in  = 1'b1;
                  fstat_in = status;
               end else if (streak_upd == IDLE_POLLS_NEEDED) begin
                  idle_in    = poll_next;
                  poll_in    = '0;
                  streak_in  = '0;
                  phase_in   = PH_PKT_ACK;
                  req_pkt_in = 1'b1;
               end else begin
                  poll_in = poll_next;
                  if (poll_next >= max_polls_ff) begin
                     idle_in  = max_polls_ff;
                     done_in  = 1'b1;
                     fstat_in = ST_TIMEOUT;
                  end
               end
            end
         end
         PH_PKT_ACK: begin
            if (req_ch.kind == K_ACK) begin
               if (status == ST_OK) begin
                  phase_in   = PH_BUF_ACK;
                  req_buf_in = 1'b1;
               end else begin
                  done_in  = 1'b1;
                  fstat_in = status;
               end
            end
         end
         PH_BUF_ACK: begin
            if (req_ch.kind == K_ACK) begin
               done_in  = 1'b1;
               fstat_in = status;
            end
         end
         default: begin
            phase_in = PH_NONE;
         end
      endcase

      if (done_in) begin
         phase_in  = PH_NONE;
         poll_in   = '0;
         streak_in = '0;
         case (fstat_in)
            ST_OK:      succ_in = succ_ff + 1'b1;
            ST_TIMEOUT: tout_in = tout_ff + 1'b1;
            default:    fail_in = fail_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_polls_ff <= MAX_POLLS_RESET;
      end else if (csr_wr_en) begin
         max_polls_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NONE;
         poll_ff   <= '0;
         streak_ff <= '0;
         drain_ff  <= '0;
         idle_ff   <= '0;
         succ_ff   <= '0;
         tout_ff   <= '0;
         fail_ff   <= '0;
      end else if (req_fire) begin
         phase_ff  <= phase_in;
         poll_ff   <= poll_in;
         streak_ff <= streak_in;
         drain_ff  <= drain_in;
         idle_ff   <= idle_in;
         succ_ff   <= succ_in;
         tout_ff   <= tout_in;
         fail_ff   <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         done_ff    <= done_in;
         fstat_ff   <= fstat_in;
         req_pkt_ff <= req_pkt_in;
         req_buf_ff <= req_buf_in;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.sequence_done        = done_ff;
   assign rsp_ch.final_status         = fstat_ff;
   assign rsp_ch.request_packet_reset = req_pkt_ff;
   assign rsp_ch.request_buffer_reset = req_buf_ff;
   assign rsp_ch.drain_polls_used     = drain_ff;
   assign rsp_ch.idle_polls_used      = idle_ff;
   assign rsp_ch.completed_total      = succ_ff;
   assign rsp_ch.timeout_total        = tout_ff;
   assign rsp_ch.failure_total        = fail_ff;

`ifndef ASSERT_OFF
   a_done_excl_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !req_pkt_ff && !req_buf_ff)
      else $error("done beat also carries a reset request");

   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !done_ff |-> fstat_ff == ST_OK)
      else $error("nonzero status on a beat that did not end the sequence");

   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> phase_ff == PH_NONE && poll_ff == '0)
      else $error("sequence ended but phase or poll count not cleared");

   a_one_total: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> $countones({succ_ff != $past(succ_ff), tout_ff != $past(tout_ff),
                               fail_ff != $past(fail_ff)}) <= 1)
      else $error("more than one outcome counter moved on one beat");

   a_streak_cap: assert property (@(posedge clock) disable iff (reset)
      streak_ff <= IDLE_POLLS_NEEDED)
      else $error("idle streak above saturation");
`endif

endmodule

`default_nettype wire
